### rtl/amdbp_pkg.sv
// amdbp_pkg: shared types and fixed widths for the diagonal bit-parallel
// approximate matcher; depends on nothing, used by every other file but amdbp_queue
package amdbp_pkg;

   // payload widths fixed by the item format
   localparam int SYMBOL_W  = 7;
   localparam int SLOT_W    = 4;
   localparam int POS_W     = 32;
   localparam int LEN_W     = 5;
   localparam int ERR_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 5;

   // largest error count the error field can hold, plus one
   localparam int ERR_SPAN  = 1 << ERR_W;

   // configuration reset values
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);
   localparam logic [ERR_W-1:0] ERR_RESET = ERR_W'(0);

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TEXT = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 1'b0,
      CSR_MAX_ERRORS     = 1'b1
   } csr_index_type;

endpackage

### rtl/amdbp_channels.sv
// amdbp_channels: valid/ready channel interfaces for request and response beats
// depends on amdbp_pkg
interface amdbp_req_if;
   logic                                valid;
   logic                                ready;
   amdbp_pkg::cmd_type                  command;
   logic [amdbp_pkg::SYMBOL_W-1:0]      symbol;
   logic [amdbp_pkg::SLOT_W-1:0]        pattern_slot;

   modport source (output valid, command, symbol, pattern_slot, input ready);
   modport sink   (input valid, command, symbol, pattern_slot, output ready);
endinterface

interface amdbp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                match_found;
   logic [amdbp_pkg::POS_W-1:0]         end_position;

   modport source (output valid, match_found, end_position, input ready);
   modport sink   (input valid, match_found, end_position, output ready);
endinterface

### rtl/amdbp_cfg.sv
// amdbp_cfg: configuration registers and the masks derived from them
// depends on amdbp_pkg
module amdbp_cfg #(
   parameter int MAX_PATTERN  = 16,
   parameter int VECTOR_WIDTH = 64
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_we,
   input  amdbp_pkg::csr_index_type                   csr_index,
   input  logic [amdbp_pkg::CSR_DAT_W-1:0]            csr_wdata,
   output logic [amdbp_pkg::ERR_W-1:0]                max_errors,
   output logic                                       cfg_busy,
   output logic                                       usable,
   output logic [VECTOR_WIDTH-1:0]                    d_init,
   output logic [VECTOR_WIDTH-1:0]                    m1,
   output logic [VECTOR_WIDTH-1:0]                    m2,
   output logic [VECTOR_WIDTH-1:0]                    low,
   output logic [VECTOR_WIDTH-1:0]                    tap_valid,
   output logic [$clog2(MAX_PATTERN)-1:0]             tap_src [VECTOR_WIDTH],
   output logic [3:0]                                 blk_shift,
   output logic [3:0]                                 diag_shift
);
   localparam int PIDX_W = $clog2(MAX_PATTERN);
   localparam int VIDX_W = $clog2(VECTOR_WIDTH);
   localparam int MAX_BLOCKS = VECTOR_WIDTH / 2;

   logic [amdbp_pkg::LEN_W-1:0] len_ff, len_in;
   logic [amdbp_pkg::ERR_W-1:0] err_ff, err_in;
   logic                        settle_ff;

   logic                        usable_ff, usable_in;
   logic [VECTOR_WIDTH-1:0]     d_init_ff, d_init_in;
   logic [VECTOR_WIDTH-1:0]     m1_ff, m1_in;
   logic [VECTOR_WIDTH-1:0]     low_ff, low_in;
   logic [VECTOR_WIDTH-1:0]     tv_ff, tv_in;
   logic [PIDX_W-1:0]           src_ff [VECTOR_WIDTH];
   logic [PIDX_W-1:0]           src_in [VECTOR_WIDTH];
   logic [3:0]                  bsh_ff, bsh_in;
   logic [3:0]                  dsh_ff, dsh_in;

   // register writes
   always_comb begin
      len_in = len_ff;
      err_in = err_ff;
      if (csr_we) begin
         unique case (csr_index)
            amdbp_pkg::CSR_PATTERN_LENGTH: len_in = csr_wdata[amdbp_pkg::LEN_W-1:0];
            amdbp_pkg::CSR_MAX_ERRORS:     err_in = csr_wdata[amdbp_pkg::ERR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= amdbp_pkg::LEN_RESET;
         err_ff    <= amdbp_pkg::ERR_RESET;
         settle_ff <= 1'b1;
      end else begin
         len_ff    <= len_in;
         err_ff    <= err_in;
         settle_ff <= csr_we;
      end
   end

   // derived masks, rebuilt from the registers every cycle
   always_comb begin
      int n;
      int w;
      n = int'(len_ff) - int'(err_ff);
      w = int'(err_ff) + 2;
      usable_in = (len_ff != '0) && (int'(len_ff) <= MAX_PATTERN) &&
                  (err_ff < len_ff) && (n * w <= VECTOR_WIDTH);
      d_init_in = '0;
      m1_in     = '0;
      tv_in     = '0;
      low_in    = '0;
      for (int p = 0; p < VECTOR_WIDTH; p++) begin
         src_in[p] = '0;
      end
      for (int i = 0; i < amdbp_pkg::ERR_SPAN; i++) begin
         if (i <= int'(err_ff) && i < VECTOR_WIDTH) begin
            low_in[i] = 1'b1;
         end
      end
      if (usable_in) begin
         for (int b = 0; b < MAX_BLOCKS; b++) begin
            if (b < n) begin
               m1_in[VIDX_W'(b * w)] = 1'b1;
               for (int i = 0; i < amdbp_pkg::ERR_SPAN; i++) begin
                  if (i <= int'(err_ff)) begin
                     d_init_in[VIDX_W'(b * w + i)] = 1'b1;
                     tv_in[VIDX_W'(b * w + i)]     = 1'b1;
                     // diagonal 0 sits in the highest block
                     src_in[VIDX_W'(b * w + i)]    = PIDX_W'(n - 1 - b + i);
                  end
               end
            end
         end
      end
      bsh_in = 4'(w);
      dsh_in = 4'(w + 1);
   end

   always_ff @(posedge clock) begin
      usable_ff <= usable_in;
      d_init_ff <= d_init_in;
      m1_ff     <= m1_in;
      low_ff    <= low_in;
      tv_ff     <= tv_in;
      src_ff    <= src_in;
      bsh_ff    <= bsh_in;
      dsh_ff    <= dsh_in;
   end

   assign max_errors = err_ff;
   assign cfg_busy   = csr_we | settle_ff;
   assign usable     = usable_ff;
   assign d_init     = d_init_ff;
   assign m1         = m1_ff;
   assign m2         = (m1_ff ^ VECTOR_WIDTH'(1)) | low_ff;
   assign low        = low_ff;
   assign tap_valid  = tv_ff;
   assign tap_src    = src_ff;
   assign blk_shift  = bsh_ff;
   assign diag_shift = dsh_ff;

endmodule

### rtl/amdbp_front.sv
// amdbp_front: accepts request beats, keeps the pattern characters and
// builds the per-character mismatch mask; depends on amdbp_pkg, amdbp_channels
module amdbp_front #(
   parameter int MAX_PATTERN   = 16,
   parameter int ALPHABET_BITS = 7
) (
   input  logic                          clock,
   amdbp_req_if.sink                     req,
   input  logic                          cfg_busy,
   input  logic [amdbp_pkg::ERR_W-1:0]   max_errors,
   input  logic                          q_full,
   output logic                          q_push,
   output logic                          q_is_text,
   output logic                          q_in_prefix,
   output logic [MAX_PATTERN-1:0]        q_diff
);
   localparam int PIDX_W = $clog2(MAX_PATTERN);

   logic [ALPHABET_BITS-1:0] pat_ff [MAX_PATTERN];
   logic [ALPHABET_BITS-1:0] sym;
   logic                     accept;

   assign req.ready = !q_full && !cfg_busy;
   assign accept    = req.valid && req.ready;
   assign sym       = ALPHABET_BITS'(req.symbol);

   // pattern store, no reset: entries are only meaningful once loaded
   always_ff @(posedge clock) begin
      if (accept && req.command == amdbp_pkg::CMD_LOAD &&
          int'(req.pattern_slot) < MAX_PATTERN) begin
         pat_ff[PIDX_W'(req.pattern_slot)] <= sym;
      end
   end

   always_comb begin
      q_in_prefix = 1'b0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         q_diff[j] = (pat_ff[j] != sym);
         if (j <= int'(max_errors) && pat_ff[j] == sym) begin
            q_in_prefix = 1'b1;
         end
      end
   end

   assign q_push    = accept;
   assign q_is_text = (req.command == amdbp_pkg::CMD_TEXT);

endmodule

### rtl/amdbp_queue.sv
// amdbp_queue: short first-in first-out buffer between front and back
// depends on nothing
module amdbp_queue #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             not_empty,
   output logic             full
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CNT_W'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != CNT_W'(DEPTH)))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("queue pop while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count lost a beat");

endmodule

### rtl/amdbp_back.sv
// amdbp_back: automaton vector update, text position and response register
// depends on amdbp_pkg, amdbp_channels
module amdbp_back #(
   parameter int MAX_PATTERN  = 16,
   parameter int VECTOR_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic                               usable,
   input  logic [VECTOR_WIDTH-1:0]            d_init,
   input  logic [VECTOR_WIDTH-1:0]            m1,
   input  logic [VECTOR_WIDTH-1:0]            m2,
   input  logic [VECTOR_WIDTH-1:0]            low,
   input  logic [VECTOR_WIDTH-1:0]            tap_valid,
   input  logic [$clog2(MAX_PATTERN)-1:0]     tap_src [VECTOR_WIDTH],
   input  logic [3:0]                         blk_shift,
   input  logic [3:0]                         diag_shift,
   input  logic [amdbp_pkg::ERR_W-1:0]        max_errors,
   input  logic                               q_not_empty,
   input  logic                               q_is_text,
   input  logic                               q_in_prefix,
   input  logic [MAX_PATTERN-1:0]             q_diff,
   output logic                               q_pop,
   amdbp_rsp_if.source                        rsp
);
   localparam int VIDX_W = $clog2(VECTOR_WIDTH);

   logic                          init_ff, init_in;
   logic [VECTOR_WIDTH-1:0]       vec_ff, vec_in;
   logic [amdbp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                          rv_ff, rv_in;
   logic                          rm_ff, rm_in;
   logic [amdbp_pkg::POS_W-1:0]   rp_ff, rp_in;

   logic [VECTOR_WIDTH-1:0]       d_cur, t, x, upd, d_next;
   logic                          hit, proceed, pop_text, pop_load, out_free;

   assign out_free = !rv_ff || rsp.ready;
   assign q_pop    = q_not_empty && (!q_is_text || out_free);
   assign pop_text = q_pop && q_is_text;
   assign pop_load = q_pop && !q_is_text;

   // vector stands at its initial value right after any restart
   assign d_cur = init_ff ? d_init : vec_ff;

   always_comb begin
      for (int p = 0; p < VECTOR_WIDTH; p++) begin
         t[p] = tap_valid[p] & q_diff[tap_src[p]];
      end
   end

   // shift-add-mask step over all diagonals
   assign x   = (d_cur >> blk_shift) | t;
   assign upd = ((d_cur << 1) | m1) & ((d_cur << diag_shift) | m2) &
                (((x + m1) ^ x) >> 1) & d_init;
   assign hit     = !upd[VIDX_W'(max_errors)];
   assign d_next  = hit ? (upd | low) : upd;
   assign proceed = usable && ((d_cur != d_init) || q_in_prefix);

   always_comb begin
      init_in = init_ff;
      vec_in  = vec_ff;
      pos_in  = pos_ff;
      rv_in   = rv_ff && !rsp.ready;
      rm_in   = rm_ff;
      rp_in   = rp_ff;
      if (restart || pop_load) begin
         init_in = 1'b1;
         pos_in  = '0;
      end else if (pop_text) begin
         pos_in = pos_ff + 1'b1;
         rv_in  = 1'b1;
         rm_in  = proceed && hit;
         rp_in  = pos_ff;
         if (proceed) begin
            init_in = 1'b0;
            vec_in  = d_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b1;
         pos_ff  <= '0;
         rv_ff   <= 1'b0;
      end else begin
         init_ff <= init_in;
         pos_ff  <= pos_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      rm_ff  <= rm_in;
      rp_ff  <= rp_in;
   end

   assign rsp.valid        = rv_ff;
   assign rsp.match_found  = rm_ff;
   assign rsp.end_position = rp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      pop_text |-> (!rv_ff || rsp.ready))
      else $error("response register overwritten before taken");

   a_hit_refills_low: assert property (@(posedge clock) disable iff (reset)
      (pop_text && proceed && hit) |=> ((vec_ff & $past(low)) == $past(low)))
      else $error("low bits not set after a match");

   a_no_match_unusable: assert property (@(posedge clock) disable iff (reset)
      (pop_text && !usable) |=> (rv_ff && !rm_ff))
      else $error("match reported for unusable configuration");

   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      (pop_text && !restart) |=> (rp_ff == $past(pos_ff) && pos_ff == rp_ff + 1'b1))
      else $error("text position did not advance by one");

endmodule

### rtl/approx_match_diagonal_bitparallel_top.sv
// approx_match_diagonal_bitparallel_top: top level of the approximate matcher
// depends on amdbp_pkg, amdbp_channels, amdbp_cfg, amdbp_front, amdbp_queue, amdbp_back
//
// Approximate string matcher using the diagonal-wise bit-parallel automaton.
// A beat with command load stores one pattern character at pattern_slot and
// restarts the automaton and the text position; it returns no response. A beat
// with command text returns exactly one response: match_found is set when an
// occurrence with at most max_errors edits of the first pattern_length
// characters ends at this character, and end_position is the text index since
// the last restart. It takes one request beat per cycle while the queue has room
// and no csr write is settling: the front compares the character against every
// pattern character in parallel, a two-entry queue decouples it from the back,
// and the back performs the whole shift-add-mask vector update combinationally.
// A response passes the queue and the response register; a stalled response stops
// only text beats, loads keep draining. Any csr write restarts the automaton;
// req ready drops during the write cycle and the one after it while the
// derived masks are rebuilt. Settings with k >= m or (m-k)(k+2) above the
// vector width never report a match but still count positions.
module approx_match_diagonal_bitparallel_top #(
   parameter int MAX_PATTERN   = 16,
   parameter int ALPHABET_BITS = 7,
   parameter int VECTOR_WIDTH  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   amdbp_req_if.sink                         req_chan,
   amdbp_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  amdbp_pkg::csr_index_type          csr_index,
   input  logic [amdbp_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   localparam int PIDX_W      = $clog2(MAX_PATTERN);
   localparam int Q_WIDTH     = MAX_PATTERN + 2;
   localparam int QUEUE_DEPTH = 2;

   // configuration and derived masks
   logic [amdbp_pkg::ERR_W-1:0] max_errors;
   logic                        cfg_busy, usable;
   logic [VECTOR_WIDTH-1:0]     d_init, m1, m2, low, tap_valid;
   logic [PIDX_W-1:0]           tap_src [VECTOR_WIDTH];
   logic [3:0]                  blk_shift, diag_shift;

   // front to queue
   logic                        q_push, f_is_text, f_in_prefix, q_full;
   logic [MAX_PATTERN-1:0]      f_diff;

   // queue to back
   logic                        q_pop, q_not_empty;
   logic [Q_WIDTH-1:0]          q_head;

   amdbp_cfg #(
      .MAX_PATTERN  (MAX_PATTERN),
      .VECTOR_WIDTH (VECTOR_WIDTH)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .max_errors (max_errors),
      .cfg_busy   (cfg_busy),
      .usable     (usable),
      .d_init     (d_init),
      .m1         (m1),
      .m2         (m2),
      .low        (low),
      .tap_valid  (tap_valid),
      .tap_src    (tap_src),
      .blk_shift  (blk_shift),
      .diag_shift (diag_shift)
   );

   // accept and classify, build the mismatch mask
   amdbp_front #(
      .MAX_PATTERN   (MAX_PATTERN),
      .ALPHABET_BITS (ALPHABET_BITS)
   ) u_front (
      .clock       (clock),
      .req         (req_chan),
      .cfg_busy    (cfg_busy),
      .max_errors  (max_errors),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_is_text   (f_is_text),
      .q_in_prefix (f_in_prefix),
      .q_diff      (f_diff)
   );

   amdbp_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_is_text, f_in_prefix, f_diff}),
      .pop       (q_pop),
      .head_data (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // automaton update and response register
   amdbp_back #(
      .MAX_PATTERN  (MAX_PATTERN),
      .VECTOR_WIDTH (VECTOR_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_we),
      .usable      (usable),
      .d_init      (d_init),
      .m1          (m1),
      .m2          (m2),
      .low         (low),
      .tap_valid   (tap_valid),
      .tap_src     (tap_src),
      .blk_shift   (blk_shift),
      .diag_shift  (diag_shift),
      .max_errors  (max_errors),
      .q_not_empty (q_not_empty),
      .q_is_text   (q_head[Q_WIDTH-1]),
      .q_in_prefix (q_head[Q_WIDTH-2]),
      .q_diff      (q_head[MAX_PATTERN-1:0]),
      .q_pop       (q_pop),
      .rsp         (rsp_chan)
   );

endmodule

### dv/approx_match_diagonal_bitparallel_top_test.sv
// approx_match_diagonal_bitparallel_top_test: self-checking bench for the diagonal
// bit-parallel approximate matcher, with its own automaton predictor and scoreboard
// depends on amdbp_pkg, amdbp_channels and approx_match_diagonal_bitparallel_top
`timescale 1ns / 1ps

module approx_match_diagonal_bitparallel_top_test;

   localparam int PATTERN_SLOTS = 16;
   localparam int VEC_W         = 64;
   localparam int PHASES        = 16;
   localparam int PHASE_BEATS   = 110;     // request beats per phase, loads included
   localparam int HOLD_PHASE    = 2;       // phase that runs into the long response hold
   localparam int HOLD_SPAN     = 300;     // cycles the response side holds off
   localparam int SETTLE_CYCLES = 8;       // lets trailing loads clear before a csr write
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct packed {
      logic        match_found;
      logic [31:0] end_position;
   } match_beat_type;

   typedef struct packed {
      amdbp_pkg::cmd_type command;
      logic [6:0]         symbol;
      logic [3:0]         slot;
      logic               typed;          // expected response written in by hand
      match_beat_type     typed_beat;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_we;
   amdbp_pkg::csr_index_type        csr_index;
   logic [amdbp_pkg::CSR_DAT_W-1:0] csr_wdata;

   amdbp_req_if req_chan ();
   amdbp_rsp_if rsp_chan ();

   approx_match_diagonal_bitparallel_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor state: pattern store, settings, diagonal vector, text index
   // ---------------------------------------------------------------------------
   logic [6:0]                  pat_chars [PATTERN_SLOTS];
   logic [amdbp_pkg::LEN_W-1:0] cur_len;
   logic [amdbp_pkg::ERR_W-1:0] cur_err;
   logic [VEC_W-1:0]            diag_vec;
   logic [31:0]                 text_index;

   match_beat_type pending_matches [$];   // expected response beats, oldest first
   stim_row_type   stim_rows [$];

   int  beats_sent   = 0;
   int  rsp_seen     = 0;
   int  fail_count   = 0;
   int  cycles_run   = 0;
   bit  tx_gaps_on   = 1'b1;
   bit  rx_stalls_on = 1'b1;
   bit  hold_armed   = 1'b0;
   logic rsp_hold    = 1'b0;

   int phase_len [PHASES] = '{1, 16, 16, 16, 14, 8, 5, 6, 16, 0, 3, 31, 10, 12, 2, 7};
   int phase_err [PHASES] = '{0, 0, 2, 3, 7, 7, 1, 2, 1, 0, 5, 1, 3, 4, 1, 7};

   // block value repeated n times at stride w, lowest block last placed
   function automatic logic [VEC_W-1:0] tile_block(logic [VEC_W-1:0] blk, int n, int w);
      logic [VEC_W-1:0] v;
      v = '0;
      for (int i = 0; i < n; i++)
         v = (v << w) | blk;
      return v;
   endfunction

   // settings that do not fit the vector never match
   function automatic bit config_usable();
      int m;
      int k;
      m = cur_len;
      k = cur_err;
      if (m == 0 || m > PATTERN_SLOTS || k >= m)
         return 1'b0;
      return (m - k) * (k + 2) <= VEC_W;
   endfunction

   // all diagonal bits set, separators clear
   function automatic logic [VEC_W-1:0] idle_vector();
      int m;
      int k;
      m = cur_len;
      k = cur_err;
      if (!config_usable())
         return '0;
      return tile_block((64'd1 << (k + 1)) - 64'd1, m - k, k + 2);
   endfunction

   task automatic restart_automaton();
      diag_vec   = idle_vector();
      text_index = '0;
   endtask

   // one shift-add-mask step for a text symbol; returns the response it causes
   function automatic match_beat_type score_text_symbol(logic [6:0] c);
      int m;
      int k;
      int w;
      int n;
      logic [VEC_W-1:0] low;
      logic [VEC_W-1:0] d_in;
      logic [VEC_W-1:0] m1;
      logic [VEC_W-1:0] m2;
      logic [VEC_W-1:0] diff;
      logic [VEC_W-1:0] t;
      logic [VEC_W-1:0] x;
      logic [VEC_W-1:0] d;
      bit in_prefix;
      match_beat_type r;
      m = cur_len;
      k = cur_err;
      r.match_found  = 1'b0;
      r.end_position = text_index;
      text_index     = text_index + 32'd1;
      if (config_usable()) begin
         w    = k + 2;
         n    = m - k;
         low  = (64'd1 << (k + 1)) - 64'd1;
         d_in = tile_block(low, n, w);
         m1   = tile_block(64'd1, n, w);
         m2   = (m1 ^ 64'd1) | low;
         in_prefix = 1'b0;
         for (int j = 0; j <= k && j < m; j++)
            if (pat_chars[j] == c)
               in_prefix = 1'b1;
         d = diag_vec;
         // idle vector and a symbol outside the first k+1 pattern chars: no change
         if (d != d_in || in_prefix) begin
            diff = '0;
            for (int j = 0; j < m; j++)
               if (pat_chars[j] != c)
                  diff[j] = 1'b1;
            // diagonal 0 sits in the highest block
            t = '0;
            for (int j = 0; j < n; j++)
               t = (t << w) | ((diff >> j) & low);
            x = (d >> w) | t;
            d = ((d << 1) | m1) & ((d << (k + 3)) | m2) & (((x + m1) ^ x) >> 1) & d_in;
            if (!d[k]) begin
               r.match_found = 1'b1;
               d = d | low;
            end
            diag_vec = d;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // offers one request beat after a random gap and updates the predictor once taken
   task automatic send_beat(input amdbp_pkg::cmd_type cmd, input logic [6:0] sym,
                            input logic [3:0] slot, input logic typed,
                            input match_beat_type typed_beat);
      int gap;
      match_beat_type predicted;
      gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.symbol       <= sym;
      req_chan.pattern_slot <= slot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      beats_sent++;
      if (cmd == amdbp_pkg::CMD_LOAD) begin
         // every load restarts the automaton and the text index
         pat_chars[slot] = sym;
         restart_automaton();
      end else begin
         predicted = score_text_symbol(sym);
         pending_matches.push_back(typed ? typed_beat : predicted);
      end
   endtask

   // csr write while the block is idle; any write restarts the automaton
   task automatic write_csr(input amdbp_pkg::csr_index_type idx,
                            input logic [amdbp_pkg::CSR_DAT_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == amdbp_pkg::CSR_PATTERN_LENGTH)
         cur_len = data;
      else
         cur_err = data[amdbp_pkg::ERR_W-1:0];
      restart_automaton();
      @(posedge clock);
   endtask

   task automatic add_row(input amdbp_pkg::cmd_type cmd, input logic [6:0] sym,
                          input logic [3:0] slot, input logic typed, input logic hit,
                          input logic [31:0] pos);
      stim_row_type row;
      row.command    = cmd;
      row.symbol     = sym;
      row.slot       = slot;
      row.typed      = typed;
      row.typed_beat = {hit, pos};
      stim_rows.push_back(row);
   endtask

   // one setting: idle the block, write both registers, load a full pattern,
   // then stream noisy copies of it mixed with noise and the odd reload
   task automatic run_phase(input int p);
      logic [6:0] alphabet [4];
      int start;
      int pick;
      int len;
      int e;
      req_chan.valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(amdbp_pkg::CSR_PATTERN_LENGTH, amdbp_pkg::CSR_DAT_W'(phase_len[p]));
      // upper bits of the error write are don't-care, toggle them anyway
      write_csr(amdbp_pkg::CSR_MAX_ERRORS, {2'($urandom_range(0, 3)), 3'(phase_err[p])});
      tx_gaps_on   = (p % 3 != 1);
      rx_stalls_on = (p % 4 != 2);
      for (int i = 0; i < 4; i++)
         alphabet[i] = 7'($urandom_range(0, 127));
      start = beats_sent;
      // every slot gets written before any text beat of the phase
      for (int s = 0; s < PATTERN_SLOTS; s++)
         send_beat(amdbp_pkg::CMD_LOAD, alphabet[$urandom_range(0, 3)], 4'(s), 1'b0, '0);
      if (p == HOLD_PHASE) begin
         // back-to-back requests into a held response side fill the block
         tx_gaps_on = 1'b0;
         hold_armed = 1'b1;
      end
      while (beats_sent - start < PHASE_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = cur_len;
            if (len < 1)
               len = 1;
            if (len > PATTERN_SLOTS)
               len = PATTERN_SLOTS;
            for (int j = 0; j < len; j++) begin
               e = $urandom_range(0, (cur_err == 0) ? 30 : 11);
               case (e)
                  0: send_beat(amdbp_pkg::CMD_TEXT, alphabet[$urandom_range(0, 3)], '0,
                               1'b0, '0);
                  1: ;   // dropped char
                  2: begin
                     send_beat(amdbp_pkg::CMD_TEXT, alphabet[$urandom_range(0, 3)], '0,
                               1'b0, '0);
                     send_beat(amdbp_pkg::CMD_TEXT, pat_chars[j], '0, 1'b0, '0);
                  end
                  default: send_beat(amdbp_pkg::CMD_TEXT, pat_chars[j], '0, 1'b0, '0);
               endcase
            end
         end else if (pick < 80) begin
            send_beat(amdbp_pkg::CMD_TEXT, alphabet[$urandom_range(0, 3)], '0, 1'b0, '0);
         end else if (pick < 96) begin
            send_beat(amdbp_pkg::CMD_TEXT, 7'($urandom_range(0, 127)),
                      4'($urandom_range(0, 15)), 1'b0, '0);
         end else begin
            // reload mid-stream restarts the search
            send_beat(amdbp_pkg::CMD_LOAD, alphabet[$urandom_range(0, 3)],
                      4'($urandom_range(0, 15)), 1'b0, '0);
         end
      end
   endtask

   initial begin : stimulus
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= amdbp_pkg::CMD_LOAD;
      req_chan.symbol       <= '0;
      req_chan.pattern_slot <= '0;
      csr_we                <= 1'b0;
      csr_index             <= amdbp_pkg::CSR_PATTERN_LENGTH;
      csr_wdata             <= '0;
      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      cur_len = amdbp_pkg::LEN_RESET;
      cur_err = amdbp_pkg::ERR_RESET;
      restart_automaton();
      @(posedge clock);

      // directed part under the reset settings: 4 chars, exact match only
      add_row(amdbp_pkg::CMD_LOAD, 7'h7F, 4'd15, 1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_LOAD, 7'h00, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_LOAD, 7'h7F, 4'd1,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_LOAD, 7'h55, 4'd2,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_LOAD, 7'h2A, 4'd3,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h00, 4'd0,  1'b1, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h7F, 4'd15, 1'b1, 1'b0, 32'd1);
      add_row(amdbp_pkg::CMD_TEXT, 7'h55, 4'd0,  1'b1, 1'b0, 32'd2);
      add_row(amdbp_pkg::CMD_TEXT, 7'h2A, 4'd0,  1'b1, 1'b1, 32'd3);   // exact occurrence
      add_row(amdbp_pkg::CMD_TEXT, 7'h11, 4'd0,  1'b1, 1'b0, 32'd4);
      add_row(amdbp_pkg::CMD_TEXT, 7'h00, 4'd0,  1'b1, 1'b0, 32'd5);
      add_row(amdbp_pkg::CMD_TEXT, 7'h7F, 4'd0,  1'b1, 1'b0, 32'd6);
      add_row(amdbp_pkg::CMD_TEXT, 7'h55, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h2B, 4'd0,  1'b0, 1'b0, 32'd0);   // one char off
      add_row(amdbp_pkg::CMD_TEXT, 7'h2A, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_LOAD, 7'h2B, 4'd3,  1'b0, 1'b0, 32'd0);   // restart, new last char
      add_row(amdbp_pkg::CMD_TEXT, 7'h2A, 4'd0,  1'b1, 1'b0, 32'd0);   // idle vector, filtered
      add_row(amdbp_pkg::CMD_TEXT, 7'h00, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h7F, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h55, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h2B, 4'd0,  1'b1, 1'b1, 32'd4);
      add_row(amdbp_pkg::CMD_TEXT, 7'h7F, 4'd0,  1'b0, 1'b0, 32'd0);
      add_row(amdbp_pkg::CMD_TEXT, 7'h00, 4'd0,  1'b1, 1'b0, 32'd6);
      foreach (stim_rows[i])
         send_beat(stim_rows[i].command, stim_rows[i].symbol, stim_rows[i].slot,
                   stim_rows[i].typed, stim_rows[i].typed_beat);

      // random part, one setting per phase, extremes and unusable ones included
      for (int p = 0; p < PHASES; p++)
         run_phase(p);

      req_chan.valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_matches.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response side: random stalls, long hold once, scoreboard compare per beat
   // ---------------------------------------------------------------------------
   initial begin : response_side
      int stall;
      match_beat_type want;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
         if (stall > 0 || rsp_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         rsp_seen++;
         if (pending_matches.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("response beat %0d with nothing expected: match_found=%0b pos=%0d",
                        rsp_seen, rsp_chan.match_found, rsp_chan.end_position);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_chan.match_found !== want.match_found ||
                rsp_chan.end_position !== want.end_position) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response beat %0d mismatch: exp match_found=%0b pos=%0d, got %0b %0d",
                           rsp_seen, want.match_found, want.end_position,
                           rsp_chan.match_found, rsp_chan.end_position);
            end
         end
      end
   end

   // long back-pressure stretch, counted here so the sender keeps offering beats
   initial begin : response_hold
      int hold_cycles;
      hold_cycles = 0;
      wait (hold_armed);
      rsp_hold <= 1'b1;
      while (hold_cycles < HOLD_SPAN) begin
         @(posedge clock);
         hold_cycles++;
      end
      rsp_hold <= 1'b0;
   end

   // run limit
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
